@@ hw/rtl/bica_pkg.sv @@
// ----------------------------------------------------------------------------
// bica_pkg
// Shared types, command codes and icon tables for the battery icon animator.
// ----------------------------------------------------------------------------
package bica_pkg;

   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_LEVEL  = 2'd1;
   localparam logic [1:0] CMD_CHARGE = 2'd2;

   localparam logic [6:0] OUTLINE_BITS = 7'h0F;
   localparam logic [6:0] FILL_FIRST   = 7'h40;
   localparam logic [6:0] FILL_SECOND  = 7'h20;
   localparam logic [6:0] FILL_THIRD   = 7'h10;
   localparam logic [1:0] TOP_LEVEL    = 2'd3;

   localparam logic [15:0] BLINK_PERIOD_RESET = 16'd500;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic       charging_now;
      logic [1:0] real_level;
      logic [1:0] shown_level;
      logic [6:0] row_mask;
   } rsp_type;

   function automatic logic [1:0] high_frame(input logic [1:0] lvl);
      logic [1:0] f;
      f = (lvl >= 2'd2) ? 2'd3 : ((lvl == 2'd1) ? 2'd2 : 2'd1);
      return f;
   endfunction

   function automatic logic [1:0] low_frame(input logic [1:0] lvl);
      logic [1:0] f;
      f = (lvl >= 2'd2) ? 2'd2 : ((lvl == 2'd1) ? 2'd1 : 2'd0);
      return f;
   endfunction

   function automatic logic [6:0] fill_row(input logic [1:0] lvl);
      logic [6:0] m;
      m = OUTLINE_BITS;
      if (lvl >= 2'd1) m = m | FILL_FIRST;
      if (lvl >= 2'd2) m = m | FILL_SECOND;
      if (lvl >= TOP_LEVEL) m = m | FILL_THIRD;
      return m;
   endfunction

endpackage

@@ hw/rtl/bica_in_reg.sv @@
// ----------------------------------------------------------------------------
// bica_in_reg
// Input register: captures one command beat and holds it until it advances.
// ----------------------------------------------------------------------------
module bica_in_reg import bica_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_beat,
   input  logic    advance,
   output logic    held_valid,
   output req_type held_beat
);

   logic    valid_ff;
   logic    valid_in;
   req_type beat_ff;

   assign in_ready = !valid_ff || advance;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         beat_ff <= in_beat;
      end
   end

   assign held_valid = valid_ff;
   assign held_beat  = beat_ff;

endmodule

@@ hw/rtl/bica_engine.sv @@
// ----------------------------------------------------------------------------
// bica_engine
// Icon state, blink period register and the per-command update logic.
// ----------------------------------------------------------------------------
module bica_engine import bica_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  req_type     beat,
   input  logic        csr_write,
   input  logic [15:0] csr_value,
   output rsp_type     result
);

   logic [15:0] period_ff;
   logic [1:0]  level_ff, level_in;
   logic        chg_ff, chg_in;
   logic [1:0]  frame_ff, frame_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [15:0] tick_cnt;
   logic [1:0]  clamped;
   logic        chg_req;
   logic [1:0]  shown;

   assign tick_cnt = (elapsed_ff < period_ff) ? (elapsed_ff + 16'd1) : elapsed_ff;
   assign clamped  = (beat.value > {6'd0, TOP_LEVEL}) ? TOP_LEVEL : beat.value[1:0];
   assign chg_req  = |beat.value;

   always_comb begin
      level_in   = level_ff;
      chg_in     = chg_ff;
      frame_in   = frame_ff;
      elapsed_in = elapsed_ff;
      unique case (beat.command)
         CMD_TICK: begin
            elapsed_in = tick_cnt;
            if (chg_ff && (tick_cnt >= period_ff)) begin
               elapsed_in = 16'd0;
               frame_in   = (frame_ff == high_frame(level_ff)) ? low_frame(level_ff)
                                                               : high_frame(level_ff);
            end
         end
         CMD_LEVEL: begin
            level_in = clamped;
            // restart the animation only on a real change
            if (chg_ff && (clamped != level_ff)) begin
               frame_in   = high_frame(clamped);
               elapsed_in = 16'd0;
            end
         end
         CMD_CHARGE: begin
            if (chg_req != chg_ff) begin
               chg_in = chg_req;
               if (chg_req) begin
                  frame_in   = high_frame(level_ff);
                  elapsed_in = 16'd0;
               end else begin
                  frame_in = level_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign shown = chg_in ? frame_in : level_in;

   always_comb begin
      result.row_mask     = fill_row(shown);
      result.shown_level  = shown;
      result.real_level   = level_in;
      result.charging_now = chg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff   <= 2'd0;
         chg_ff     <= 1'b0;
         frame_ff   <= 2'd0;
         elapsed_ff <= 16'd0;
      end else if (step) begin
         level_ff   <= level_in;
         chg_ff     <= chg_in;
         frame_ff   <= frame_in;
         elapsed_ff <= elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= BLINK_PERIOD_RESET;
      end else if (csr_write) begin
         period_ff <= csr_value;
      end
   end

   a_clamp_level: assert property (@(posedge clock) disable iff (reset)
      step && (beat.command == CMD_LEVEL) && (beat.value > 8'd3) |=> level_ff == TOP_LEVEL)
      else $error("level above three not clamped");

   a_charge_start: assert property (@(posedge clock) disable iff (reset)
      step && (beat.command == CMD_CHARGE) && chg_req && !chg_ff
      |=> (elapsed_ff == 16'd0) && (frame_ff == high_frame(level_ff)))
      else $error("charge start did not restart the animation");

   a_frame_pair: assert property (@(posedge clock) disable iff (reset)
      chg_ff |-> (frame_ff == high_frame(level_ff)) || (frame_ff == low_frame(level_ff)))
      else $error("frame outside the blink pair of the level");

   a_idle_period_hold: assert property (@(posedge clock) disable iff (reset)
      !csr_write |=> $stable(period_ff))
      else $error("blink period changed without a write");

endmodule

@@ hw/rtl/bica_out_reg.sv @@
// ----------------------------------------------------------------------------
// bica_out_reg
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module bica_out_reg import bica_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    load_valid,
   input  rsp_type load_beat,
   input  logic    out_ready,
   output logic    out_valid,
   output rsp_type out_beat,
   output logic    advance
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type beat_ff;

   // free when empty or when the held beat leaves this cycle
   assign advance  = !valid_ff || out_ready;
   assign valid_in = advance ? load_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && load_valid) begin
         beat_ff <= load_beat;
      end
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule

@@ hw/rtl/battery_icon_charge_animator.sv @@
// ----------------------------------------------------------------------------
// battery_icon_charge_animator
// A command beat passes the input register, then its result loads the result
// register once that register is free.
// Throughput: one command beat per cycle while no result beat stalls; during a
// stall, req_tready drops once the input register holds a command beat.
// Reset (synchronous): level, charging flag, frame and tick count clear,
// blink period returns to 500.
// ----------------------------------------------------------------------------
module battery_icon_charge_animator import bica_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] value
   input  logic [1:0]            req_tuser,   // [1:0] command
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [6:0] row_mask, [8:7] shown_level, [10:9] real_level, [11] charging_now
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [15:0]           csr_data
);

   req_type in_beat;
   req_type held_beat;
   logic    held_valid;
   logic    advance;
   logic    step;
   rsp_type result;
   rsp_type out_beat;

   assign in_beat.command = req_tuser;
   assign in_beat.value   = req_tdata;
   assign step            = held_valid && advance;
   assign csr_ready       = 1'b1;

   bica_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_beat    (in_beat),
      .advance    (advance),
      .held_valid (held_valid),
      .held_beat  (held_beat)
   );

   bica_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .beat      (held_beat),
      .csr_write (csr_valid && csr_ready),
      .csr_value (csr_data),
      .result    (result)
   );

   bica_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (held_valid),
      .load_beat  (result),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_beat   (out_beat),
      .advance    (advance)
   );

   assign rsp_tdata = {4'd0, out_beat};

endmodule
